FILE: rtl/picture_downscaler_2_3_macros.svh
// Assertion macros used by the checker file.
`ifndef PICTURE_DOWNSCALER_2_3_MACROS_SVH
`define PICTURE_DOWNSCALER_2_3_MACROS_SVH

// Plain property checked while out of reset.
`define PDS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pds assertion failed");

// A stalled beat keeps its valid and its payload into the next cycle.
`define PDS_ASSERT_HOLD(lbl, clk, rst_n, vld, stl, data) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && stl) |=> (vld && $stable(data))) \
        else $error("pds hold assertion failed");

`endif

FILE: rtl/pds_pkg.sv
// Package: types, register indexes and arithmetic helpers of the downscaler.
package pds_pkg;

    localparam int DEF_MAX_OUT_WIDTH = 1024;
    localparam int SAMPLE_BITS       = 8;
    localparam int COUNT_BITS        = 12;
    localparam int CFG_IDX_BITS      = 3;
    localparam int CFG_DATA_BITS     = 11;

    localparam logic [CFG_IDX_BITS-1:0] CFG_H_FACTOR     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_V_FACTOR     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_H_FILTER     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_V_FILTER     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIELD_OFFSET = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_HEIGHT   = 3'd6;

    localparam logic [1:0] FILT_DROP = 2'd0;
    localparam logic [1:0] FILT_BOX  = 2'd1;

    // Vertical modes after the factor and field offset are folded in.
    localparam logic [1:0] VM_DROP = 2'd0;
    localparam logic [1:0] VM_BOX3 = 2'd1;
    localparam logic [1:0] VM_BOX2 = 2'd2;
    localparam logic [1:0] VM_121  = 2'd3;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   line_end;
        logic                   frame_end;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] out_sample;
        logic                   out_line_end;
        logic                   out_frame_end;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  h_factor;
        logic [1:0]  v_factor;
        logic [1:0]  h_filter;
        logic [1:0]  v_filter;
        logic        field_offset;
        logic [10:0] out_width;
        logic [10:0] out_height;
    } t_cfg;

    // Shrunken sample handed from the horizontal to the vertical stage.
    typedef struct packed {
        logic                   valid;
        logic [SAMPLE_BITS-1:0] hv;
        logic [COUNT_BITS-1:0]  row;
        logic                   le;
    } t_hreq;

    // Division by three of a sum of three samples, by reciprocal.
    function automatic logic [SAMPLE_BITS-1:0] div3_sum(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd683;
        return p[18:11];
    endfunction

    // Division by three of a row number.
    function automatic logic [10:0] div3_row(input logic [COUNT_BITS-1:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd2731;
        return p[23:13];
    endfunction

endpackage

FILE: rtl/pds_hfilt.sv
// Horizontal stage: column and row counters and the horizontal filter.
module pds_hfilt import pds_pkg::*; #(
    parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_acc,
    input  t_cfg                              i_cfg,
    input  t_in_item                          i_item,
    output t_hreq                             o_req,
    output logic [$clog2(MAX_OUT_WIDTH)-1:0]  o_idx
);
    localparam int WB   = $clog2(MAX_OUT_WIDTH + 1);
    localparam int CMPW = (WB + 1 > COUNT_BITS) ? WB + 1 : COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0]  r_col, r_row;
    logic [1:0]             r_col3;
    logic [WB-1:0]          r_occ;
    logic [SAMPLE_BITS-1:0] r_p1, r_p2;

    logic [WB-1:0]          w;
    logic                   hf3, hval;
    logic [SAMPLE_BITS-1:0] hv;
    logic [SAMPLE_BITS-1:0] s;
    logic [9:0]             sum3;

    assign s   = i_item.sample;
    assign hf3 = (i_cfg.h_factor == 2'd3);
    assign w   = (CMPW'(i_cfg.out_width) > CMPW'(MAX_OUT_WIDTH)) ?
                 WB'(MAX_OUT_WIDTH) : WB'(i_cfg.out_width);

    always_comb begin
        hval = 1'b0;
        hv   = '0;
        sum3 = '0;
        if (i_cfg.h_filter == FILT_DROP) begin
            hval = hf3 ? (r_col3 == 2'd0) : !r_col[0];
            hv   = s;
        end else if (hf3) begin
            hval = (r_col3 == 2'd1);
            // The missing left neighbor of the first column repeats column zero.
            sum3 = (r_col == COUNT_BITS'(1)) ? ({1'b0, r_p1, 1'b0} + 10'(s)) :
                   (10'(r_p2) + 10'(r_p1) + 10'(s));
            hv   = div3_sum(sum3);
        end else if (i_cfg.h_filter == FILT_BOX) begin
            hval = r_col[0];
            sum3 = 10'(r_p1) + 10'(s);
            hv   = sum3[8:1];
        end else if (w != '0 && CMPW'(r_col) == (CMPW'(w) << 1) - CMPW'(1)) begin
            hval = 1'b1;
            sum3 = 10'(r_p1) + 10'(s) + {1'b0, s, 1'b0};
            hv   = sum3[9:2];
        end else if (r_col >= COUNT_BITS'(2) && !r_col[0] &&
                     (CMPW'(r_occ) + CMPW'(1)) < CMPW'(w)) begin
            hval = 1'b1;
            sum3 = 10'(r_p2) + {1'b0, r_p1, 1'b0} + 10'(s);
            hv   = sum3[9:2];
        end
    end

    assign o_req.valid = hval && (r_occ < w);
    assign o_req.hv    = hv;
    assign o_req.row   = r_row;
    assign o_req.le    = ((r_occ + WB'(1)) == w);
    assign o_idx       = r_occ[$clog2(MAX_OUT_WIDTH)-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_col3 <= '0;
            r_row  <= '0;
            r_occ  <= '0;
            r_p1   <= '0;
            r_p2   <= '0;
        end else if (i_acc) begin
            r_p2 <= r_p1;
            r_p1 <= s;
            if (o_req.valid) begin
                r_occ <= r_occ + WB'(1);
            end
            if (i_item.line_end || i_item.frame_end) begin
                r_col  <= '0;
                r_col3 <= '0;
                r_occ  <= '0;
                if (i_item.frame_end) begin
                    r_row <= '0;
                end else if (r_row != CNT_MAX) begin
                    r_row <= r_row + COUNT_BITS'(1);
                end
            end else if (r_col != CNT_MAX) begin
                r_col  <= r_col + COUNT_BITS'(1);
                r_col3 <= (r_col3 == 2'd2) ? 2'd0 : r_col3 + 2'd1;
            end
        end
    end

endmodule

FILE: rtl/pds_vfilt.sv
// Vertical stage: two-line store, vertical filter and the output register.
module pds_vfilt import pds_pkg::*; #(
    parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_acc,
    input  t_cfg                              i_cfg,
    input  t_hreq                             i_req,
    input  logic [$clog2(MAX_OUT_WIDTH)-1:0]  i_idx,
    output logic                              o_valid,
    output t_out_item                         o_item
);
    logic [SAMPLE_BITS-1:0] r_mem0 [MAX_OUT_WIDTH];
    logic [SAMPLE_BITS-1:0] r_mem1 [MAX_OUT_WIDTH];

    logic [1:0]            vmode;
    logic                  ok, emit, rem_nz, vf3;
    logic [COUNT_BITS-1:0] r, x, rem;
    logic [10:0]           q3;
    logic [COUNT_BITS-1:0] k;
    logic                  wr0, wr1;

    logic                   r_s_valid, r_s_par, r_s_small, r_s_le, r_s_fe;
    logic [1:0]             r_s_mode;
    logic [SAMPLE_BITS-1:0] r_s_hv, r_rd0, r_rd1;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [SAMPLE_BITS-1:0] a, b, v;
    logic [9:0]             sum;

    assign r   = i_req.row;
    assign vf3 = (i_cfg.v_factor == 2'd3);

    always_comb begin
        if (i_cfg.v_filter == FILT_DROP) begin
            vmode = VM_DROP;
        end else if (vf3) begin
            vmode = VM_BOX3;
        end else if (i_cfg.v_filter == FILT_BOX || i_cfg.field_offset) begin
            vmode = VM_BOX2;
        end else begin
            vmode = VM_121;
        end
    end

    always_comb begin
        ok = 1'b0;
        x  = '0;
        case (vmode)
            VM_DROP: begin
                ok = (r >= COUNT_BITS'(i_cfg.field_offset));
                x  = r - COUNT_BITS'(i_cfg.field_offset);
            end
            VM_BOX3: begin
                ok = (r >= COUNT_BITS'(i_cfg.field_offset) + COUNT_BITS'(1));
                x  = r - COUNT_BITS'(i_cfg.field_offset) - COUNT_BITS'(1);
            end
            VM_BOX2: begin
                ok = r[0];
                x  = r;
            end
            VM_121: begin
                ok = r[0];
                x  = r - COUNT_BITS'(1);
            end
            default: begin
                ok = 1'b0;
                x  = '0;
            end
        endcase
        q3     = div3_row(x);
        rem    = x - COUNT_BITS'(q3) - {q3, 1'b0};
        rem_nz = (rem != '0);
        if (vmode == VM_BOX3 || (vmode == VM_DROP && vf3)) begin
            k = COUNT_BITS'(q3);
            if (rem_nz) begin
                ok = 1'b0;
            end
        end else begin
            k = x >> 1;
            if (vmode == VM_DROP && x[0]) begin
                ok = 1'b0;
            end
        end
        emit = i_req.valid && ok && (k < COUNT_BITS'(i_cfg.out_height));
    end

    // Slot selection: factor-3 box and (1,2,1) rotate by row parity,
    // factor-2 box keeps the even line in slot zero.
    always_comb begin
        wr0 = 1'b0;
        wr1 = 1'b0;
        case (vmode)
            VM_BOX3, VM_121: begin
                wr0 = !r[0];
                wr1 = r[0];
            end
            VM_BOX2: wr0 = !r[0];
            default: begin
                wr0 = 1'b0;
                wr1 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_rd0 <= r_mem0[i_idx];
            r_rd1 <= r_mem1[i_idx];
            if (i_req.valid && wr0) begin
                r_mem0[i_idx] <= i_req.hv;
            end
            if (i_req.valid && wr1) begin
                r_mem1[i_idx] <= i_req.hv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s_mode  <= vmode;
            r_s_par   <= r[0];
            r_s_small <= (vmode == VM_BOX3) ? (r < COUNT_BITS'(2)) :
                         (r == COUNT_BITS'(1));
            r_s_hv    <= i_req.hv;
            r_s_le    <= i_req.le;
            r_s_fe    <= i_req.le &&
                         (k + COUNT_BITS'(1) == COUNT_BITS'(i_cfg.out_height));
        end
    end

    always_comb begin
        a   = '0;
        b   = '0;
        sum = '0;
        v   = r_s_hv;
        case (r_s_mode)
            VM_BOX3: begin
                b   = r_s_par ? r_rd0 : r_rd1;
                a   = r_s_small ? b : (r_s_par ? r_rd1 : r_rd0);
                sum = 10'(a) + 10'(b) + 10'(r_s_hv);
                v   = div3_sum(sum);
            end
            VM_BOX2: begin
                sum = 10'(r_rd0) + 10'(r_s_hv);
                v   = sum[8:1];
            end
            VM_121: begin
                b   = r_rd0;
                a   = r_s_small ? b : r_rd1;
                sum = 10'(a) + {1'b0, b, 1'b0} + 10'(r_s_hv);
                v   = sum[9:2];
            end
            default: v = r_s_hv;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_s_valid   <= i_acc && emit;
            r_out_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.out_sample    <= v;
            r_out.out_line_end  <= r_s_le;
            r_out.out_frame_end <= r_s_fe;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

FILE: rtl/picture_downscaler_2_3.sv
// Each accepted sample is counted, filtered horizontally and written to or read
// from the two-line store in its accept cycle; one more register stage applies
// the vertical filter and the result leaves from an output register. One
// sample is taken every clock as long as the output is not stalled. A stall
// on the output holds the whole pipeline, and o_in_stall is raised only while
// a finished beat waits. The line store holds two shrunken lines of up to
// MAX_OUT_WIDTH samples each.
module picture_downscaler_2_3 import pds_pkg::*; #(
    parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_item                 i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out
);
    t_cfg  r_cfg;
    t_hreq req;
    logic  en, acc;
    logic [$clog2(MAX_OUT_WIDTH)-1:0] idx;

    assign en         = !(o_out_valid && i_out_stall);
    assign acc        = i_in_valid && en;
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.h_factor     <= 2'd2;
            r_cfg.v_factor     <= 2'd2;
            r_cfg.h_filter     <= FILT_BOX;
            r_cfg.v_filter     <= FILT_BOX;
            r_cfg.field_offset <= 1'b0;
            r_cfg.out_width    <= 11'd360;
            r_cfg.out_height   <= 11'd288;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_H_FACTOR:     r_cfg.h_factor     <= i_cfg_data[1:0];
                CFG_V_FACTOR:     r_cfg.v_factor     <= i_cfg_data[1:0];
                CFG_H_FILTER:     r_cfg.h_filter     <= i_cfg_data[1:0];
                CFG_V_FILTER:     r_cfg.v_filter     <= i_cfg_data[1:0];
                CFG_FIELD_OFFSET: r_cfg.field_offset <= i_cfg_data[0];
                CFG_OUT_WIDTH:    r_cfg.out_width    <= i_cfg_data;
                CFG_OUT_HEIGHT:   r_cfg.out_height   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pds_hfilt #(.MAX_OUT_WIDTH(MAX_OUT_WIDTH)) u_hfilt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_cfg   (r_cfg),
        .i_item  (i_in),
        .o_req   (req),
        .o_idx   (idx)
    );

    pds_vfilt #(.MAX_OUT_WIDTH(MAX_OUT_WIDTH)) u_vfilt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_acc   (acc),
        .i_cfg   (r_cfg),
        .i_req   (req),
        .i_idx   (idx),
        .o_valid (o_out_valid),
        .o_item  (o_out)
    );

endmodule

FILE: rtl/pds_checker.sv
// Port-level checker for the downscaler and its bind to the top level.
`include "picture_downscaler_2_3_macros.svh"

module pds_checker import pds_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);
    // A waiting output beat keeps its contents.
    `PDS_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, o_out_valid, i_out_stall, o_out)

    // The input side stalls only behind a stalled output beat.
    `PDS_ASSERT(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall))

    // The last beat of a frame also closes its line.
    `PDS_ASSERT(a_frame_line, i_clk, i_rst_n, (o_out_valid && o_out.out_frame_end) |-> o_out.out_line_end)

    // An idle input brings no new beat to the output; only a stalled beat may stay.
    `PDS_ASSERT(a_latency, i_clk, i_rst_n, (!i_in_valid ##1 (!i_in_valid && !o_in_stall) ##1 !o_out_valid) |=> !o_out_valid || $past(i_out_stall))

endmodule

bind picture_downscaler_2_3 pds_checker u_pds_checker (.*);

FILE: test/tb.sv
// Self-checking testbench of the 2x/3x picture downscaler.
`timescale 1ns / 100ps

module tb;
    import pds_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    t_in_item                 i_in;
    logic                     o_out_valid;
    logic                     i_out_stall;
    t_out_item                o_out;

    picture_downscaler_2_3 DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mirror of the block's registers and state.
    logic [1:0]  m_hfac, m_vfac, m_hfilt, m_vfilt;
    logic        m_offset;
    logic [10:0] m_width, m_height;
    int unsigned m_prev1, m_prev2, m_col, m_row, m_ocol;
    logic [7:0]  m_store [2048];

    t_out_item   scaled_q [$];
    int          fail_count = 0;
    int          in_beats = 0;
    int          out_beats = 0;
    int          frames_sent = 0;
    int          cycles = 0;
    bit          idle_on = 1'b0;
    int          rx_wait = 0;

    function automatic int unsigned slot_addr(int unsigned slot, int unsigned i);
        return ((slot & 1) * 1024 + i) % 2048;
    endfunction

    // Computes the scaled sample caused by one input beat, if any.
    task automatic scale_step(input t_in_item it);
        int unsigned s, w, hf, vf, o, c, r, p1, p2, hv, i, k, v, a, b;
        bit hvalid, emit, le;
        t_out_item res;
        s = it.sample;
        w = (m_width > 1024) ? 1024 : m_width;
        hf = (m_hfac == 2'd3) ? 3 : 2;
        vf = (m_vfac == 2'd3) ? 3 : 2;
        o = m_offset;
        c = m_col; r = m_row; p1 = m_prev1; p2 = m_prev2;
        hvalid = 0; hv = 0; emit = 0; k = 0; v = 0;
        if (m_hfilt == FILT_DROP) begin
            if (c % hf == 0) begin hvalid = 1; hv = s; end
        end else if (hf == 3) begin
            if (c % 3 == 1) begin
                hvalid = 1;
                hv = (c == 1) ? (2 * p1 + s) / 3 : (p2 + p1 + s) / 3;
            end
        end else if (m_hfilt == FILT_BOX) begin
            if (c % 2 == 1) begin hvalid = 1; hv = (p1 + s) / 2; end
        end else begin
            if (w > 0 && c == 2 * w - 1) begin
                hvalid = 1; hv = (p1 + 3 * s) / 4;
            end else if (c >= 2 && c % 2 == 0 && m_ocol + 1 < w) begin
                hvalid = 1; hv = (p2 + 2 * p1 + s) / 4;
            end
        end
        if (hvalid && m_ocol < w) begin
            i = m_ocol;
            if (m_vfilt == FILT_DROP) begin
                if (r >= o && (r - o) % vf == 0) begin
                    emit = 1; k = (r - o) / vf; v = hv;
                end
            end else if (vf == 3) begin
                if (r >= 1 + o && (r - 1 - o) % 3 == 0) begin
                    b = m_store[slot_addr(r + 1, i)];
                    a = (r < 2) ? b : m_store[slot_addr(r, i)];
                    emit = 1; k = (r - 1 - o) / 3; v = (a + b + hv) / 3;
                end
                m_store[slot_addr(r, i)] = hv[7:0];
            end else if (m_vfilt == FILT_BOX || o != 0) begin
                if (r % 2 == 1) begin
                    emit = 1; k = r / 2; v = (m_store[slot_addr(0, i)] + hv) / 2;
                end else begin
                    m_store[slot_addr(0, i)] = hv[7:0];
                end
            end else begin
                if (r % 2 == 1) begin
                    b = m_store[slot_addr(0, i)];
                    a = (r == 1) ? b : m_store[slot_addr(1, i)];
                    emit = 1; k = (r - 1) / 2; v = (a + 2 * b + hv) / 4;
                end
                m_store[slot_addr(r, i)] = hv[7:0];
            end
            if (emit && k < m_height) begin
                le = (i + 1 == w);
                res.out_sample = v[7:0];
                res.out_line_end = le;
                res.out_frame_end = le && (k + 1 == m_height);
                scaled_q.push_back(res);
            end
            m_ocol = i + 1;
        end
        m_prev2 = p1;
        m_prev1 = s;
        if (it.line_end || it.frame_end) begin
            m_col = 0;
            m_ocol = 0;
            if (it.frame_end) m_row = 0;
            else if (r < 4095) m_row = r + 1;
        end else if (c < 4095) begin
            m_col = c + 1;
        end
    endtask

    // Sends one beat; valid stays high afterwards for a back-to-back beat.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        in_beats++;
        scale_step(it);
    endtask

    // Called at the step of the last acceptance; valid drops here exactly once.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (scaled_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller drops it after its last write.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_H_FACTOR:     m_hfac = val[1:0];
            CFG_V_FACTOR:     m_vfac = val[1:0];
            CFG_H_FILTER:     m_hfilt = val[1:0];
            CFG_V_FILTER:     m_vfilt = val[1:0];
            CFG_FIELD_OFFSET: m_offset = val[0];
            CFG_OUT_WIDTH:    m_width = val;
            CFG_OUT_HEIGHT:   m_height = val;
            default: ;
        endcase
    endtask

    task automatic set_cfg(input int hfac, input int vfac, input int hfilt,
                           input int vfilt, input int offs, input int w, input int h);
        write_reg(CFG_H_FACTOR, CFG_DATA_BITS'(hfac));
        write_reg(CFG_V_FACTOR, CFG_DATA_BITS'(vfac));
        write_reg(CFG_H_FILTER, CFG_DATA_BITS'(hfilt));
        write_reg(CFG_V_FILTER, CFG_DATA_BITS'(vfilt));
        write_reg(CFG_FIELD_OFFSET, CFG_DATA_BITS'(offs));
        write_reg(CFG_OUT_WIDTH, CFG_DATA_BITS'(w));
        write_reg(CFG_OUT_HEIGHT, CFG_DATA_BITS'(h));
        i_cfg_we <= 1'b0;
    endtask

    // One frame of nlines lines of len samples. Pattern: 0 random, 1 all ones,
    // 2 all zeros, 3 alternating. Short lines only where no line store is read.
    task automatic send_frame(input int nlines, input int len, input int pat,
                              input bit short_lines, input bit pause_mid);
        t_in_item it;
        int n;
        for (int ln = 0; ln < nlines; ln++) begin
            n = short_lines ? $urandom_range(1, len) : len;
            for (int c = 0; c < n; c++) begin
                case (pat)
                    1: it.sample = 8'hFF;
                    2: it.sample = 8'h00;
                    3: it.sample = (c[0] ^ ln[0]) ? 8'hFF : 8'h00;
                    default: it.sample = 8'($urandom_range(0, 255));
                endcase
                it.frame_end = (ln == nlines - 1) && (c == n - 1);
                it.line_end = (c == n - 1) ?
                              (it.frame_end ? 1'($urandom_range(0, 1)) : 1'b1) : 1'b0;
                send_item(it);
                if (pause_mid && ln == nlines / 2 && c == 0) begin
                    // Hold off the sender until the scaled stream has caught up.
                    i_in_valid <= 1'b0;
                    do @(posedge i_clk); while (scaled_q.size() != 0);
                end
            end
        end
        frames_sent++;
        wait_drained();
    endtask

    // A frame sized so that every line store entry read was written first.
    task automatic full_frame(input int pat, input int extra_cols, input int extra_rows);
        int hf, vf, w;
        hf = (m_hfac == 2'd3) ? 3 : 2;
        vf = (m_vfac == 2'd3) ? 3 : 2;
        w = (m_width > 1024) ? 1024 : m_width;
        send_frame(vf * m_height + m_offset + extra_rows,
                   (w == 0 ? 1 : hf * w) + extra_cols, pat, 1'b0, 1'b0);
    endtask

    task automatic test_filters();
        idle_on = 1'b0;
        for (int hfac = 2; hfac <= 3; hfac++)
            for (int hfilt = 0; hfilt <= 3; hfilt++) begin
                set_cfg(hfac, 2, hfilt, 1, 0, 2, 1);
                full_frame(hfilt, 0, 0);
            end
        for (int vfac = 2; vfac <= 3; vfac++)
            for (int vfilt = 0; vfilt <= 3; vfilt++)
                for (int offs = 0; offs <= 1; offs++) begin
                    set_cfg(2, vfac, 0, vfilt, offs, 1, 2);
                    full_frame(vfilt, 0, 0);
                end
    endtask

    task automatic test_extremes();
        idle_on = 1'b1;
        set_cfg(2, 2, 2, 2, 0, 1, 1);
        full_frame(0, 2, 0);
        set_cfg(2, 2, 1, 1, 0, 0, 2);
        send_frame(2, 4, 0, 1'b0, 1'b0);
        set_cfg(2, 2, 1, 1, 0, 2, 0);
        send_frame(2, 4, 0, 1'b0, 1'b0);
        set_cfg(3, 2, 0, 0, 1, 1, 2047);
        send_frame(5, 3, 0, 1'b0, 1'b0);
    endtask

    task automatic test_short_lines();
        idle_on = 1'b1;
        set_cfg(3, 2, 1, 0, 1, 4, 3);
        send_frame(6, 10, 0, 1'b1, 1'b0);
    endtask

    task automatic test_random();
        int hfac, vfac, hfilt, vfilt, offs, w, h;
        for (int f = 0; f < 4; f++) begin
            idle_on = ($urandom_range(0, 3) != 0);
            hfac = $urandom_range(1, 3);
            vfac = $urandom_range(1, 3);
            hfilt = $urandom_range(0, 3);
            vfilt = $urandom_range(0, 3);
            offs = $urandom_range(0, 1);
            w = $urandom_range(1, 3);
            h = $urandom_range(1, 2);
            set_cfg(hfac, vfac, hfilt, vfilt, offs, w, h);
            if (vfilt == 0 && $urandom_range(0, 3) == 0)
                send_frame(h * 3 + 1, w * 3 + 2, 0, 1'b1, 1'b0);
            else
                send_frame((vfac == 3 ? 3 : 2) * h + offs + $urandom_range(0, 2),
                           (hfac == 3 ? 3 : 2) * w + $urandom_range(0, 3),
                           0, 1'b0, f == 1);
        end
    endtask

    // Output side: check each accepted beat, then draw the next stall stretch.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            out_beats++;
            if (scaled_q.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $realtime, o_out);
                fail_count++;
            end else begin
                if (o_out !== scaled_q[0]) begin
                    $display("%0t: mismatch, expected sample %0d le %0d fe %0d, actual %0d %0d %0d",
                             $realtime, scaled_q[0].out_sample, scaled_q[0].out_line_end,
                             scaled_q[0].out_frame_end, o_out.out_sample,
                             o_out.out_line_end, o_out.out_frame_end);
                    fail_count++;
                end
                void'(scaled_q.pop_front());
            end
            rx_wait = idle_on ? $urandom_range(0, 9) : 0;
        end
        if (rx_wait > 0) begin
            i_out_stall <= 1'b1;
            rx_wait--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        m_hfac = 2'd2; m_vfac = 2'd2; m_hfilt = 2'd1; m_vfilt = 2'd1;
        m_offset = 1'b0; m_width = 11'd360; m_height = 11'd288;
        m_prev1 = 0; m_prev2 = 0; m_col = 0; m_row = 0; m_ocol = 0;
        foreach (m_store[j]) m_store[j] = 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_filters();
        test_extremes();
        test_short_lines();
        test_random();

        while (scaled_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (scaled_q.size() != 0) begin
            $display("%0d expected beats never arrived", scaled_q.size());
            fail_count++;
        end
        $display("Sent %0d frames (%0d input beats) over all factors, filters and offsets,",
                 frames_sent, in_beats);
        $display("checked %0d scaled beats with %0d mismatches.", out_beats, fail_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
